/* rtl/core/sha1bh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 block hash package
// Shared types and constants for the SHA-1 block hash core.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned ROUND_W     = 7;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    localparam word_t IV [HASH_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam word_t RK0 = 32'h5a827999;
    localparam word_t RK1 = 32'h6ed9eba1;
    localparam word_t RK2 = 32'h8f1bbcdc;
    localparam word_t RK3 = 32'hca62c1d6;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] PHASE1     = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] PHASE2     = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] PHASE3     = ROUND_W'(60);
    localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(BLOCK_WORDS - 1);

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

/* rtl/core/sha1_block_hash_core.sv */
// ----------------------------------------------------------------------------
// SHA-1 block hash core
// Hashes a padded message given as 32-bit big-endian words, one round per
// cycle on a single shared round unit, and returns the 160-bit digest.
// ----------------------------------------------------------------------------
// Channel   Ports        Contents
// input     s_axis_*     tdata: message word, tuser: start of message,
//                        tlast: last word of the final block
// result    m_axis_*     tdata: digest words 0..4, word 0 lowest
//
// A word that does not complete a block is taken while the core is idle. The
// sixteenth word of a block starts 80 rounds of the shared round unit, one
// per cycle, and the finish state then adds the result into the chaining
// value. The input is not ready during the rounds and the chaining update.
// The digest sits in an output register, so the next block can be taken
// while it waits; the chaining update stalls only if a second digest is due
// before the first has been taken. Reset loads the initial vector.
module sha1_block_hash_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sha1bh_pkg::WORD_W-1:0]       s_axis_tdata,  // message_word
    input  logic [0:0]                          s_axis_tuser,  // start_message
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // digest_word0, digest_word1, digest_word2, digest_word3, digest_word4
    output logic [sha1bh_pkg::HASH_WORDS*sha1bh_pkg::WORD_W-1:0] m_axis_tdata
);
    import sha1bh_pkg::*;

    state_t state_reg, state_next;

    word_t sched_reg [BLOCK_WORDS];
    word_t chain_reg [HASH_WORDS];
    word_t var_reg   [HASH_WORDS];
    word_t chain_sum [HASH_WORDS];

    logic [POS_W-1:0]   pos_reg;
    logic [ROUND_W-1:0] round_reg;
    logic               emit_reg;
    logic               out_valid_reg;
    logic [HASH_WORDS*WORD_W-1:0] out_data_reg;

    logic       in_fire;
    logic       out_fire;
    logic       block_done;
    logic       finish_go;
    word_t      f_val;
    word_t      k_val;
    word_t      temp_val;
    word_t      w_new;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_fire   = out_valid_reg && m_axis_tready;
    assign block_done = in_fire && !s_axis_tuser[0] && (pos_reg == POS_LAST);
    assign finish_go  = !emit_reg || !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        if (round_reg < PHASE1) begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = RK0;
        end else if (round_reg < PHASE2) begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = RK1;
        end else if (round_reg < PHASE3) begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = RK2;
        end else begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = RK3;
        end
        temp_val = rotl(var_reg[0], 5) + f_val + var_reg[4] + sched_reg[0] + k_val;
        w_new    = rotl(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0], 1);
        for (int i = 0; i < HASH_WORDS; i++) begin
            chain_sum[i] = chain_reg[i] + var_reg[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (block_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            round_reg     <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= IV[i];
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && finish_go && emit_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_axis_tuser[0]) begin
                            pos_reg <= POS_W'(1);
                            for (int i = 0; i < HASH_WORDS; i++) begin
                                chain_reg[i] <= IV[i];
                            end
                        end else begin
                            pos_reg <= pos_reg + POS_W'(1);
                        end
                        round_reg <= '0;
                        emit_reg  <= s_axis_tlast;
                    end
                end
                ST_ROUND: begin
                    round_reg <= round_reg + ROUND_W'(1);
                end
                ST_FINISH: begin
                    if (finish_go) begin
                        for (int i = 0; i < HASH_WORDS; i++) begin
                            chain_reg[i] <= chain_sum[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_fire) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= s_axis_tdata;
            if (block_done) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    var_reg[i] <= chain_reg[i];
                end
            end
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= w_new;
            var_reg[4] <= var_reg[3];
            var_reg[3] <= var_reg[2];
            var_reg[2] <= rotl(var_reg[1], 30);
            var_reg[1] <= var_reg[0];
            var_reg[0] <= temp_val;
        end
        if (state_reg == ST_FINISH && finish_go && emit_reg) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                out_data_reg[i*WORD_W +: WORD_W] <= chain_sum[i];
            end
        end
    end

endmodule
